// File: rtl/obbl_pkg.sv
// Shared types and codes of the order book best level block.
// No dependencies.
package obbl_pkg;

  typedef enum logic [2:0] {
    OP_CREATE     = 3'd0,
    OP_MODIFY     = 3'd1,
    OP_DELETE     = 3'd2,
    OP_GET        = 3'd3,
    OP_SUSPEND    = 3'd4,
    OP_REACTIVATE = 3'd5,
    OP_QUERY      = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_REJECT   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_DRAIN,
    FSM_UPDATE,
    FSM_OUT
  } fsm_e;

  // one slot, id kept apart since its width is a parameter
  typedef struct packed {
    logic [15:0]        product;
    logic               side;
    logic signed [31:0] price;
    logic signed [31:0] quantity;
    logic               active;
  } entry_t;

  typedef struct packed {
    logic [31:0] key;
    logic [15:0] product;
    logic        side;
  } scan_req_t;

  typedef struct packed {
    logic we;
    logic set;
    logic clr;
  } tbl_wr_t;

  localparam int unsigned MaxOrdersDef = 64;
  localparam int unsigned IdBitsDef    = 32;

endpackage

// File: rtl/obbl_table.sv
// Order slot memory with valid flags and a registered read port.
// Depends on obbl_pkg.
module obbl_table #(
  parameter int unsigned MAX_ORDERS = obbl_pkg::MaxOrdersDef,
  parameter int unsigned ID_BITS    = obbl_pkg::IdBitsDef,
  localparam int unsigned AW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [AW-1:0]         rd_addr_i,
  output logic                  rd_valid_o,
  output logic [ID_BITS-1:0]    rd_id_o,
  output obbl_pkg::entry_t      rd_entry_o,
  input  obbl_pkg::tbl_wr_t     wr_i,
  input  logic [AW-1:0]         wr_addr_i,
  input  logic [ID_BITS-1:0]    wr_id_i,
  input  obbl_pkg::entry_t      wr_entry_i
);

  logic [MAX_ORDERS-1:0] valid_q;
  logic [ID_BITS-1:0]    id_mem [MAX_ORDERS];
  obbl_pkg::entry_t      ent_mem [MAX_ORDERS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_o <= 1'b0;
    end else begin
      rd_valid_o <= valid_q[rd_addr_i];
      if (wr_i.set) valid_q[wr_addr_i] <= 1'b1;
      else if (wr_i.clr) valid_q[wr_addr_i] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      id_mem[wr_addr_i]  <= wr_id_i;
      ent_mem[wr_addr_i] <= wr_entry_i;
    end
    rd_id_o    <= id_mem[rd_addr_i];
    rd_entry_o <= ent_mem[rd_addr_i];
  end

endmodule

// File: rtl/obbl_scan.sv
// Shared slot compare and level accumulate unit, one slot per cycle while en_i is high.
// Depends on obbl_pkg.
module obbl_scan #(
  parameter int unsigned MAX_ORDERS = obbl_pkg::MaxOrdersDef,
  parameter int unsigned ID_BITS    = obbl_pkg::IdBitsDef,
  localparam int unsigned AW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1,
  localparam int unsigned CW = $clog2(MAX_ORDERS + 1),
  localparam int unsigned SW = (33 + AW > 41) ? 33 + AW : 41
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clr_i,
  input  logic                  en_i,
  input  logic [AW-1:0]         idx_i,
  input  logic                  slot_valid_i,
  input  logic [ID_BITS-1:0]    slot_id_i,
  input  obbl_pkg::entry_t      slot_i,
  input  obbl_pkg::scan_req_t   req_i,
  output logic                  free_found_o,
  output logic [AW-1:0]         free_idx_o,
  output logic                  match_found_o,
  output logic [AW-1:0]         match_idx_o,
  output logic [ID_BITS-1:0]    match_id_o,
  output obbl_pkg::entry_t      match_entry_o,
  output logic                  best_found_o,
  output logic signed [31:0]    best_price_o,
  output logic signed [SW-1:0]  sum_o,
  output logic [CW-1:0]         count_o
);

  localparam int unsigned KW = (ID_BITS > 32) ? ID_BITS : 32;

  logic [KW-1:0] id_ext, key_ext;
  logic          hit, lvl, better;

  assign id_ext  = KW'(slot_id_i);
  assign key_ext = KW'(req_i.key);
  assign hit     = slot_valid_i && (id_ext == key_ext);
  assign lvl     = slot_valid_i && slot_i.active && (slot_i.product == req_i.product)
                   && (slot_i.side == req_i.side);
  // buy wants the highest price, sell the lowest
  assign better  = req_i.side ? (slot_i.price < best_price_o)
                              : (slot_i.price > best_price_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_found_o  <= 1'b0;
      match_found_o <= 1'b0;
      best_found_o  <= 1'b0;
    end else if (clr_i) begin
      free_found_o  <= 1'b0;
      match_found_o <= 1'b0;
      best_found_o  <= 1'b0;
    end else if (en_i) begin
      if (!slot_valid_i && !free_found_o) free_found_o <= 1'b1;
      if (hit && !match_found_o) match_found_o <= 1'b1;
      if (lvl) best_found_o <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      sum_o   <= '0;
      count_o <= '0;
    end else if (en_i) begin
      if (!slot_valid_i && !free_found_o) free_idx_o <= idx_i;
      if (hit && !match_found_o) begin
        match_idx_o   <= idx_i;
        match_id_o    <= slot_id_i;
        match_entry_o <= slot_i;
      end
      if (lvl) begin
        if (!best_found_o || better) begin
          best_price_o <= slot_i.price;
          sum_o        <= SW'(slot_i.quantity);
          count_o      <= CW'(1);
        end else if (slot_i.price == best_price_o) begin
          sum_o   <= sum_o + SW'(slot_i.quantity);
          count_o <= count_o + CW'(1);
        end
      end
    end
  end

endmodule

// File: rtl/order_book_best_level_top.sv
// Top level of the order book best level block: sequencer, handshake, result register.
// Depends on obbl_pkg, obbl_table, obbl_scan.
//
// channel  | dir | tdata fields (low bit up)                         | tuser
// s_axis   | in  | order_key, product_code, side, price_in, quantity_in | operation
// m_axis   | out | order_out, product_out, side_out, price_out,         | status
//          |     | quantity_out, active_out, level_quantity, level_count |
//
// From accept to result the block steps through a scan of every slot, one slot a cycle
// through the table's single read port, then a drain, an update and the result state.
// The next item is accepted only after the result is taken and the block is idle again.
// Reset clears the valid flags and next id at once; slot data needs no clearing.
// s_axis_tready is high only while idle; a held result stalls the block.
module order_book_best_level_top #(
  parameter int unsigned MAX_ORDERS = obbl_pkg::MaxOrdersDef,
  parameter int unsigned ID_BITS    = obbl_pkg::IdBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [31:0] order_key, [47:32] product_code, [48] side, [80:49] price_in,
  // [112:81] quantity_in, rest zero
  input  logic [119:0]  s_axis_tdata,
  // [2:0] operation
  input  logic [2:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [31:0] order_out, [47:32] product_out, [48] side_out, [80:49] price_out,
  // [112:81] quantity_out, [113] active_out, [153:114] level_quantity,
  // [160:154] level_count, rest zero
  output logic [167:0]  m_axis_tdata,
  // [1:0] status
  output logic [1:0]    m_axis_tuser
);

  localparam int unsigned AW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
  localparam int unsigned CW = $clog2(MAX_ORDERS + 1);
  localparam int unsigned SW = (33 + AW > 41) ? 33 + AW : 41;
  localparam logic signed [SW-1:0] LqMax = SW'(40'sh7F_FFFF_FFFF);
  localparam logic signed [SW-1:0] LqMin = SW'(40'sh80_0000_0000);

  obbl_pkg::fsm_e state_q, state_d;

  // request capture
  logic [2:0]          op_q;
  obbl_pkg::scan_req_t req_q;
  logic signed [31:0]  price_q, qty_q;
  logic [ID_BITS-1:0]  next_id_q, next_id_d;
  logic [AW-1:0]       addr_q;
  logic                en_q;
  logic [AW-1:0]       idx_q;

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // table and scan wiring
  logic                rd_valid;
  logic [ID_BITS-1:0]  rd_id;
  obbl_pkg::entry_t    rd_entry;
  obbl_pkg::tbl_wr_t   wr;
  logic [AW-1:0]       wr_addr;
  logic [ID_BITS-1:0]  wr_id;
  obbl_pkg::entry_t    wr_entry;

  logic                free_found, match_found, best_found;
  logic [AW-1:0]       free_idx, match_idx;
  logic [ID_BITS-1:0]  match_id;
  obbl_pkg::entry_t    match_entry;
  logic signed [31:0]  best_price;
  logic signed [SW-1:0] sum;
  logic [CW-1:0]       count;

  obbl_table #(.MAX_ORDERS(MAX_ORDERS), .ID_BITS(ID_BITS)) u_table (
    .clk_i, .rst_ni,
    .rd_addr_i (addr_q),
    .rd_valid_o(rd_valid),
    .rd_id_o   (rd_id),
    .rd_entry_o(rd_entry),
    .wr_i      (wr),
    .wr_addr_i (wr_addr),
    .wr_id_i   (wr_id),
    .wr_entry_i(wr_entry)
  );

  obbl_scan #(.MAX_ORDERS(MAX_ORDERS), .ID_BITS(ID_BITS)) u_scan (
    .clk_i, .rst_ni,
    .clr_i        (s_acc),
    .en_i         (en_q),
    .idx_i        (idx_q),
    .slot_valid_i (rd_valid),
    .slot_id_i    (rd_id),
    .slot_i       (rd_entry),
    .req_i        (req_q),
    .free_found_o (free_found),
    .free_idx_o   (free_idx),
    .match_found_o(match_found),
    .match_idx_o  (match_idx),
    .match_id_o   (match_id),
    .match_entry_o(match_entry),
    .best_found_o (best_found),
    .best_price_o (best_price),
    .sum_o        (sum),
    .count_o      (count)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      obbl_pkg::FSM_IDLE:   if (s_axis_tvalid) state_d = obbl_pkg::FSM_SCAN;
      obbl_pkg::FSM_SCAN:   if (addr_q == AW'(MAX_ORDERS - 1)) state_d = obbl_pkg::FSM_DRAIN;
      obbl_pkg::FSM_DRAIN:  state_d = obbl_pkg::FSM_UPDATE;
      obbl_pkg::FSM_UPDATE: state_d = obbl_pkg::FSM_OUT;
      obbl_pkg::FSM_OUT:    if (m_axis_tready) state_d = obbl_pkg::FSM_IDLE;
      default:              state_d = obbl_pkg::FSM_IDLE;
    endcase
  end

  // result of the finished scan
  logic                 create_ok;
  logic [1:0]           res_status;
  logic [31:0]          res_order;
  logic [15:0]          res_product;
  logic                 res_side, res_active;
  logic signed [31:0]   res_price, res_qty;
  logic signed [39:0]   res_lq;
  logic [6:0]           res_lc;
  logic [CW+6:0]        count_ext;
  logic [ID_BITS+31:0]  id_ext;

  assign count_ext = {7'd0, count};
  assign id_ext    = {32'd0, next_id_q};
  assign create_ok = !qty_q[31] && free_found && (next_id_q != {ID_BITS{1'b1}});

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = (state_q == obbl_pkg::FSM_IDLE);
    m_axis_tvalid = (state_q == obbl_pkg::FSM_OUT);
    wr          = '0;
    wr_addr     = match_idx;
    wr_id       = match_id;
    wr_entry    = match_entry;
    next_id_d   = next_id_q;
    res_status  = obbl_pkg::ST_NOTFOUND;
    res_order   = '0;
    res_product = '0;
    res_side    = 1'b0;
    res_price   = '0;
    res_qty     = '0;
    res_active  = 1'b0;
    res_lq      = '0;
    res_lc      = '0;
    if (state_q == obbl_pkg::FSM_UPDATE) begin
      case (op_q)
        obbl_pkg::OP_CREATE: begin
          if (create_ok) begin
            wr.we             = 1'b1;
            wr.set            = 1'b1;
            wr_addr           = free_idx;
            wr_id             = next_id_q;
            wr_entry.product  = req_q.product;
            wr_entry.side     = req_q.side;
            wr_entry.price    = price_q;
            wr_entry.quantity = qty_q;
            wr_entry.active   = 1'b1;
            res_status        = obbl_pkg::ST_OK;
            res_order         = id_ext[31:0];
            next_id_d         = next_id_q + ID_BITS'(1);
          end else begin
            res_status = obbl_pkg::ST_REJECT;
          end
        end
        obbl_pkg::OP_MODIFY, obbl_pkg::OP_DELETE, obbl_pkg::OP_GET,
        obbl_pkg::OP_SUSPEND, obbl_pkg::OP_REACTIVATE: begin
          res_order = req_q.key;
          if (match_found) begin
            res_status = obbl_pkg::ST_OK;
            wr_entry   = match_entry;
            case (op_q)
              obbl_pkg::OP_MODIFY: begin
                wr.we             = 1'b1;
                wr_entry.price    = price_q;
                wr_entry.quantity = qty_q;
              end
              obbl_pkg::OP_DELETE: wr.clr = 1'b1;
              obbl_pkg::OP_GET: begin
                res_product = match_entry.product;
                res_side    = match_entry.side;
                res_price   = match_entry.price;
                res_qty     = match_entry.quantity;
                res_active  = match_entry.active;
              end
              default: begin
                // suspend or reactivate; id rewritten unchanged
                wr.we           = 1'b1;
                wr_entry.active = (op_q == obbl_pkg::OP_REACTIVATE);
              end
            endcase
          end
        end
        obbl_pkg::OP_QUERY: begin
          if (best_found) begin
            res_status = obbl_pkg::ST_OK;
            res_price  = best_price;
            res_lc     = count_ext[6:0];
            if (sum > LqMax) res_lq = LqMax[39:0];
            else if (sum < LqMin) res_lq = LqMin[39:0];
            else res_lq = sum[39:0];
          end
        end
        default: res_status = obbl_pkg::ST_NOTFOUND;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= obbl_pkg::FSM_IDLE;
      next_id_q <= '0;
      en_q      <= 1'b0;
      addr_q    <= '0;
    end else begin
      state_q   <= state_d;
      next_id_q <= next_id_d;
      en_q      <= (state_q == obbl_pkg::FSM_SCAN);
      if (s_acc) addr_q <= '0;
      else if (state_q == obbl_pkg::FSM_SCAN && addr_q != AW'(MAX_ORDERS - 1))
        addr_q <= addr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= addr_q;
    if (s_acc) begin
      op_q          <= s_axis_tuser;
      req_q.key     <= s_axis_tdata[31:0];
      req_q.product <= s_axis_tdata[47:32];
      req_q.side    <= s_axis_tdata[48];
      price_q       <= s_axis_tdata[80:49];
      qty_q         <= s_axis_tdata[112:81];
    end
    if (state_q == obbl_pkg::FSM_UPDATE) begin
      m_axis_tuser <= res_status;
      m_axis_tdata <= {7'd0, res_lc, res_lq, res_active, res_qty, res_price,
                       res_side, res_product, res_order};
    end
  end

  // results only while the input side is closed
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");

  // an accepted item starts a scan, never an immediate result
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
    else $error("accepted item did not start a scan");

  // a rejected create carries no id
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == obbl_pkg::ST_REJECT) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("rejected create shows an id");

  // next id only advances on a successful create
  a_id_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_id_q != $past(next_id_q)) |-> $past(state_q == obbl_pkg::FSM_UPDATE && create_ok
    && op_q == obbl_pkg::OP_CREATE)) else $error("next id moved unexpectedly");

endmodule
